>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/fpc_pkg.sv
// Package for the frame parse and CRC check unit: constants, types, CRC table.
package fpc_pkg;

  localparam int HEADER_BYTES  = 5;
  localparam int NAME_BYTES    = 7;
  localparam int TRAILER_BYTES = 4;
  localparam int MIN_FRAME     = HEADER_BYTES + NAME_BYTES + TRAILER_BYTES;

  localparam int POS_W   = 9;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_XOR  = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] KIND_TIER    = 3'd0;
  localparam logic [2:0] KIND_BW      = 3'd1;
  localparam logic [2:0] KIND_TYPE    = 3'd2;
  localparam logic [2:0] KIND_BLOCKS  = 3'd3;
  localparam logic [2:0] KIND_LENGTH  = 3'd4;
  localparam logic [2:0] KIND_NAME    = 3'd5;
  localparam logic [2:0] KIND_PAYLOAD = 3'd6;
  localparam logic [2:0] KIND_STATUS  = 3'd7;

  // One queue entry: the results caused by one input beat.
  typedef struct packed {
    logic        tag_vld;
    logic [2:0]  kind;
    logic [7:0]  value;
    logic        stat_vld;
    logic [31:0] rx_crc;
    logic        crc_match;
    logic        too_short;
  } fpc_entry_t;

  // Entry of the reflected CRC-32 byte table (entry 1 is 0x77073096).
  function automatic logic [31:0] crc_table(input logic [7:0] idx);
    logic [31:0] c;
    c = {24'd0, idx};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    return (crc >> 8) ^ crc_table(crc[7:0] ^ b);
  endfunction

endpackage

>>> sv/fpc_if.sv
// Valid/ready channel interfaces for the input bytes and the result items.
interface fpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       is_last;

  modport source (output valid, rx_byte, is_last, input ready);
  modport sink   (input valid, rx_byte, is_last, output ready);
endinterface

interface fpc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  value;
  logic [31:0] received_crc;
  logic        crc_match;
  logic        too_short;
  logic        frame_end;

  modport source (output valid, kind, value, received_crc, crc_match, too_short,
                  frame_end, input ready);
  modport sink   (input valid, kind, value, received_crc, crc_match, too_short,
                  frame_end, output ready);
endinterface

>>> sv/fpc_front.sv
// Front end: holdback line, byte position, CRC update and classification.
module fpc_front import fpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic       is_last,
  output logic       push,
  output fpc_entry_t entry
);

  logic [7:0]       hb_r [TRAILER_BYTES];
  logic [7:0]       hb_nxt [TRAILER_BYTES];
  logic [31:0]      crc_r, crc_nxt, crc_upd;
  logic [POS_W-1:0] pos_r, pos_nxt, pos_inc, p;
  logic [7:0]       len_r, len_nxt;
  logic             leave;
  logic [31:0]      rcrc;

  always_comb begin
    leave   = pos_r >= POS_W'(TRAILER_BYTES);
    p       = pos_r - POS_W'(TRAILER_BYTES);
    crc_upd = leave ? crc_step(crc_r, hb_r[0]) : crc_r;
    pos_inc = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;

    for (int i = 0; i < TRAILER_BYTES - 1; i++) begin
      hb_nxt[i] = hb_r[i+1];
    end
    hb_nxt[TRAILER_BYTES-1] = rx_byte;

    rcrc = '0;
    for (int i = 0; i < TRAILER_BYTES; i++) begin
      rcrc = {rcrc[23:0], hb_nxt[i]};
    end

    len_nxt = len_r;
    entry.tag_vld = 1'b0;
    entry.kind    = KIND_PAYLOAD;
    entry.value   = hb_r[0];
    if (leave) begin
      priority if (p < POS_W'(HEADER_BYTES)) begin
        entry.tag_vld = 1'b1;
        entry.kind    = p[2:0];
        if (p == POS_W'(HEADER_BYTES - 1)) len_nxt = hb_r[0];
      end else if (p < POS_W'(HEADER_BYTES + NAME_BYTES)) begin
        entry.tag_vld = 1'b1;
        entry.kind    = KIND_NAME;
      end else if ((p - POS_W'(HEADER_BYTES + NAME_BYTES)) < {1'b0, len_r}) begin
        entry.tag_vld = 1'b1;
        entry.kind    = KIND_PAYLOAD;
      end
    end

    entry.stat_vld  = is_last;
    entry.rx_crc    = rcrc;
    entry.too_short = pos_inc < POS_W'(MIN_FRAME);
    entry.crc_match = !entry.too_short && ((crc_upd ^ CRC_XOR) == rcrc);

    push    = accept && (entry.tag_vld || is_last);
    crc_nxt = crc_upd;
    pos_nxt = pos_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TRAILER_BYTES; i++) hb_r[i] <= '0;
      crc_r <= CRC_INIT;
      pos_r <= '0;
      len_r <= '0;
    end else if (accept) begin
      if (is_last) begin
        // frame done: back to the reset state for the next frame
        for (int i = 0; i < TRAILER_BYTES; i++) hb_r[i] <= '0;
        crc_r <= CRC_INIT;
        pos_r <= '0;
        len_r <= '0;
      end else begin
        for (int i = 0; i < TRAILER_BYTES; i++) hb_r[i] <= hb_nxt[i];
        crc_r <= crc_nxt;
        pos_r <= pos_nxt;
        len_r <= len_nxt;
      end
    end
  end

endmodule

>>> sv/fpc_queue.sv
// Short FIFO of result entries between the front and back ends.
module fpc_queue import fpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  fpc_entry_t push_entry,
  input  logic       pop,
  output logic       full,
  output logic       not_empty,
  output fpc_entry_t head
);

  fpc_entry_t        slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign not_empty = cnt_r != '0;
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> sv/fpc_back.sv
// Back end: turns each queue entry into one or two output beats.
module fpc_back import fpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       not_empty,
  input  fpc_entry_t head,
  output logic       pop,
  fpc_out_if.source  out_ch
);

  logic phase_r, phase_nxt;
  logic show_tag, fire;

  always_comb begin
    show_tag     = head.tag_vld && !phase_r;
    out_ch.valid = not_empty;
    fire         = not_empty && out_ch.ready;

    if (show_tag) begin
      out_ch.kind         = head.kind;
      out_ch.value        = head.value;
      out_ch.received_crc = '0;
      out_ch.crc_match    = 1'b0;
      out_ch.too_short    = 1'b0;
      out_ch.frame_end    = 1'b0;
    end else begin
      out_ch.kind         = KIND_STATUS;
      out_ch.value        = '0;
      out_ch.received_crc = head.rx_crc;
      out_ch.crc_match    = head.crc_match;
      out_ch.too_short    = head.too_short;
      out_ch.frame_end    = 1'b1;
    end

    // entry with tag and status: first beat only advances the phase
    pop       = fire && !(show_tag && head.stat_vld);
    phase_nxt = phase_r;
    if (fire) phase_nxt = show_tag && head.stat_vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) phase_r <= 1'b0;
    else        phase_r <= phase_nxt;
  end

endmodule

>>> sv/frame_parse_crc_check_unit.sv
// Top level of the frame parse and CRC-32 check unit.
// Throughput: one byte beat per cycle while the result queue has room; a frame's last
//   byte that also releases a tagged byte gives one more output beat, absorbed by the
//   4-entry result queue. With the queue empty, a tagged byte is offered the cycle after
//   the 4th byte beat behind it; status follows the last byte, after any tag it releases.
// Reset: synchronous, active low; clears holdback, CRC, position, length and the queue.
module frame_parse_crc_check_unit import fpc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  fpc_in_if.sink    in_ch,
  fpc_out_if.source out_ch
);

  // front -> queue
  logic       push;
  fpc_entry_t push_entry;
  // queue -> back
  logic       full, not_empty, pop;
  fpc_entry_t head;
  logic       accept;

  // Input is taken whenever the queue has room; the output side never
  // stalls the input directly, only through the queue filling up.
  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;

  // Front: shifts the byte through the holdback line, runs the table
  // CRC on the byte that falls out, tags it by position and builds the
  // status on the last byte of a frame.
  fpc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_ch.rx_byte),
    .is_last (in_ch.is_last),
    .push    (push),
    .entry   (push_entry)
  );

  // Queue: one entry per beat that causes at least one result.
  fpc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .not_empty  (not_empty),
    .head       (head)
  );

  // Back: tagged byte first, then status, one result beat per cycle while the receiver is ready.
  fpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

>>> sv/fpc_checker.sv
// Port-level checker for the frame parse and CRC check unit, with its bind.
`include "assert_macros.svh"

module fpc_checker import fpc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_value,
  input logic [31:0] out_received_crc,
  input logic        out_crc_match,
  input logic        out_too_short,
  input logic        out_frame_end
);

  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_value) && $stable(out_frame_end), "stalled result beat changed")
  `ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result offered right after reset")
  `ASSERT_CLK(a_end_kind, out_valid |-> (out_frame_end == (out_kind == KIND_STATUS)), "frame_end and status kind disagree")
  `ASSERT_CLK(a_tag_clean, out_valid && !out_frame_end |-> out_received_crc == '0 && !out_crc_match && !out_too_short, "status fields set on a tagged byte")
  `ASSERT_CLK(a_status_ok, out_valid && out_frame_end |-> out_value == '0 && !(out_crc_match && out_too_short), "bad status beat")

endmodule

bind frame_parse_crc_check_unit fpc_checker u_fpc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_kind         (out_ch.kind),
  .out_value        (out_ch.value),
  .out_received_crc (out_ch.received_crc),
  .out_crc_match    (out_ch.crc_match),
  .out_too_short    (out_ch.too_short),
  .out_frame_end    (out_ch.frame_end)
);

>>> verif/frame_parse_crc_check_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for the frame parse and CRC-32 check unit: directed frames, random frames, scoreboard.
module frame_parse_crc_check_unit_tb;
  import fpc_pkg::*;

  // Run sizing. The watchdog limit is far above the longest legal quiet spell:
  // a sender gap plus a receiver stall plus the unit's latency.
  localparam int ITEM_TARGET    = 1150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int LONG_PAD       = 250;  // drives one frame past the 511-byte position cap
  localparam int MAX_ERR_LINES  = 200;
  localparam int DIR_ROWS       = 20;

  // One result beat, as seen on the output channel.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  value;
    logic [31:0] received_crc;
    logic        crc_match;
    logic        too_short;
    logic        frame_end;
  } parsed_item_t;

  // One row of the directed table. A row with fcs set sends the four check bytes
  // of the frame so far instead of data. A row with has_exp carries its status typed in.
  typedef struct packed {
    logic [7:0]   data;
    logic         last;
    logic         fcs;
    logic         has_exp;
    parsed_item_t exp;
  } dir_row_t;

  typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_PERIODIC, SINK_HEAVY} sink_mode_t;

  logic clk;
  logic rst_n;

  fpc_in_if  in_ch ();
  fpc_out_if out_ch ();

  frame_parse_crc_check_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Directed part: frames shorter than the holdback, a four-byte frame, and one
  // short well-formed frame with extreme header and name bytes, one payload byte and a good CRC.
  dir_row_t dir_rows [DIR_ROWS] = '{
    // single byte right after reset: lands in the low end of the received CRC
    '{8'h00, 1'b1, 1'b0, 1'b1, '{KIND_STATUS, 8'h00, 32'h0000_0000, 1'b0, 1'b1, 1'b1}},
    '{8'hFF, 1'b1, 1'b0, 1'b1, '{KIND_STATUS, 8'h00, 32'h0000_00FF, 1'b0, 1'b1, 1'b1}},
    // exactly the holdback depth: nothing tagged, all four bytes read big-endian
    '{8'h12, 1'b0, 1'b0, 1'b0, '0},
    '{8'h34, 1'b0, 1'b0, 1'b0, '0},
    '{8'h56, 1'b0, 1'b0, 1'b0, '0},
    '{8'h78, 1'b1, 1'b0, 1'b1, '{KIND_STATUS, 8'h00, 32'h1234_5678, 1'b0, 1'b1, 1'b1}},
    // header: tier, bandwidth code, type, blocks, payload length
    '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h5A, 1'b0, 1'b0, 1'b0, '0},
    '{8'hA5, 1'b0, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, 1'b0, '0},
    // name bytes
    '{8'h80, 1'b0, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, 1'b0, '0},
    '{8'h7F, 1'b0, 1'b0, 1'b0, '0},
    '{8'hFE, 1'b0, 1'b0, 1'b0, '0},
    '{8'h55, 1'b0, 1'b0, 1'b0, '0},
    '{8'hAA, 1'b0, 1'b0, 1'b0, '0},
    '{8'h3C, 1'b0, 1'b0, 1'b0, '0},
    // one payload byte, then the check bytes
    '{8'hC3, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, 1'b0, '0}
  };

  // Parser shadow state.
  logic [7:0]       hold_q [TRAILER_BYTES];
  logic [31:0]      model_crc;
  logic [POS_W-1:0] model_pos;
  logic [7:0]       model_len;
  parsed_item_t     pending_items [$];

  // Sender state.
  logic [31:0]  tx_crc;
  int           burst_left;
  bit           row_has_exp;
  parsed_item_t row_exp;
  int           beats_sent;
  int           frame_bytes;
  int           longest_frame;

  // Scoreboard counters.
  int error_count;
  int items_checked;
  int frames_seen;
  int crc_good;
  int short_frames;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Bitwise reflected CRC-32 over one byte.
  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Append one predicted beat at the tail of the scoreboard queue.
  function automatic void queue_expected(input parsed_item_t it);
    pending_items = {pending_items, it};
  endfunction

  task automatic clear_parser();
    for (int i = 0; i < TRAILER_BYTES; i++) begin
      hold_q[i] = 8'h00;
    end
    model_crc = CRC_INIT;
    model_pos = '0;
    model_len = 8'h00;
  endtask

  // Advance the shadow parser by one accepted byte and queue the beats it causes.
  task automatic parse_byte(input logic [7:0] b, input logic l);
    logic [7:0]       old_byte;
    logic [POS_W-1:0] p;
    logic [31:0]      rx_crc;
    logic             shrt;
    logic             match;
    if (model_pos >= TRAILER_BYTES) begin
      // the byte leaving the holdback is tagged by its position in the frame
      old_byte  = hold_q[0];
      p         = model_pos - POS_W'(TRAILER_BYTES);
      model_crc = crc_update(model_crc, old_byte);
      if (p < HEADER_BYTES) begin
        if (p == HEADER_BYTES - 1) model_len = old_byte;
        // header kinds run tier..length in position order
        queue_expected('{KIND_TIER + p[2:0], old_byte, 32'd0, 1'b0, 1'b0, 1'b0});
      end else if (p < HEADER_BYTES + NAME_BYTES) begin
        queue_expected('{KIND_NAME, old_byte, 32'd0, 1'b0, 1'b0, 1'b0});
      end else if (p - (HEADER_BYTES + NAME_BYTES) < model_len) begin
        queue_expected('{KIND_PAYLOAD, old_byte, 32'd0, 1'b0, 1'b0, 1'b0});
      end
      // anything past the payload is padding: CRC only
    end
    for (int i = 0; i < TRAILER_BYTES - 1; i++) begin
      hold_q[i] = hold_q[i + 1];
    end
    hold_q[TRAILER_BYTES - 1] = b;
    if (model_pos != POS_MAX) model_pos = model_pos + 1'b1;
    if (l) begin
      rx_crc = {hold_q[0], hold_q[1], hold_q[2], hold_q[3]};
      shrt   = (model_pos < MIN_FRAME);
      match  = !shrt && ((model_crc ^ CRC_XOR) == rx_crc);
      queue_expected('{KIND_STATUS, 8'h00, rx_crc, match, shrt, 1'b1});
      clear_parser();
    end
  endtask

  task automatic flag_error(input string msg);
    if (error_count < MAX_ERR_LINES) $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string field_name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s: got %0h, expected %0h", field_name, got, want));
  endtask

  // Scoreboard: predict on every accepted input beat, check every accepted result beat.
  // Prediction runs first so the queue order never depends on process order.
  always @(posedge clk) begin : scoreboard
    parsed_item_t got;
    parsed_item_t want;
    logic         in_fire;
    logic         out_fire;
    in_fire  = rst_n && in_ch.valid && in_ch.ready;
    out_fire = rst_n && out_ch.valid && out_ch.ready;
    if (in_fire) begin
      parse_byte(in_ch.rx_byte, in_ch.is_last);
      // a directed row with a typed status stands in for the predicted one
      if (row_has_exp) pending_items[$] = row_exp;
    end
    if (out_fire) begin
      got = '{out_ch.kind, out_ch.value, out_ch.received_crc, out_ch.crc_match,
              out_ch.too_short, out_ch.frame_end};
      if (pending_items.size() == 0) begin
        flag_error($sformatf("result beat with nothing pending: kind %0d value %02h",
                             got.kind, got.value));
      end else begin
        want = pending_items.pop_front();
        check_field("kind", got.kind, want.kind);
        check_field("value", got.value, want.value);
        check_field("received_crc", got.received_crc, want.received_crc);
        check_field("crc_match", got.crc_match, want.crc_match);
        check_field("too_short", got.too_short, want.too_short);
        check_field("frame_end", got.frame_end, want.frame_end);
        items_checked++;
        if (want.frame_end) begin
          frames_seen++;
          crc_good     += want.crc_match;
          short_frames += want.too_short;
        end
      end
    end
    // watchdog: any beat on either side counts as progress
    if (in_fire || out_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: ready pattern follows one of four modes, redrawn at random.
  initial begin : sink_pacing
    sink_mode_t mode;
    int         cyc;
    out_ch.ready = 1'b0;
    mode = SINK_OPEN;
    cyc  = 0;
    forever begin
      @(negedge clk);
      if (cyc % 96 == 0) mode = sink_mode_t'($urandom_range(0, 3));
      unique case (mode)
        SINK_OPEN:     out_ch.ready <= 1'b1;
        SINK_LIGHT:    out_ch.ready <= ($urandom_range(0, 3) != 0);
        SINK_PERIODIC: out_ch.ready <= ((cyc % 9) < 5);
        SINK_HEAVY:    out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
      cyc++;
    end
  end

  // Drive one byte beat. Entered and left at a falling edge. The sender runs in
  // bursts; a burst ends in a gap with valid low.
  task automatic drive_beat(input logic [7:0] b, input logic l);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    in_ch.is_last <= l;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    frame_bytes++;
    tx_crc = crc_update(tx_crc, b);
    if (l) begin
      if (frame_bytes > longest_frame) longest_frame = frame_bytes;
      frame_bytes = 0;
      tx_crc      = CRC_INIT;
    end
    @(negedge clk);
  endtask

  // Four check bytes, MSB first; flip corrupts chosen bits.
  task automatic drive_fcs(input logic [31:0] flip);
    logic [31:0] fcs;
    fcs = (tx_crc ^ CRC_XOR) ^ flip;
    for (int k = 0; k < TRAILER_BYTES; k++) begin
      drive_beat(fcs[31 - 8*k -: 8], k == TRAILER_BYTES - 1);
    end
  endtask

  // Mostly well-formed frames with random content; some with the payload cut short,
  // some with padding or a bad CRC, the rest noise of short and medium length.
  task automatic drive_random_frame(input bit make_long);
    int          pick;
    int          len;
    int          body;
    int          pad;
    logic [31:0] flip;
    pick = make_long ? 0 : $urandom_range(0, 99);
    if (pick < 75) begin
      len  = make_long ? 255 :
             (($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12));
      body = len;
      pad  = 0;
      if (pick >= 60) begin
        if (len > 0) body = $urandom_range(0, len - 1);
      end else begin
        pad = make_long ? LONG_PAD :
              (($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0);
      end
      flip = ($urandom_range(0, 7) == 0) ? (32'd1 << $urandom_range(0, 31)) : 32'd0;
      for (int i = 0; i < HEADER_BYTES - 1; i++) begin
        drive_beat(8'($urandom_range(0, 255)), 1'b0);
      end
      drive_beat(len[7:0], 1'b0);
      for (int i = 0; i < NAME_BYTES + body + pad; i++) begin
        drive_beat(8'($urandom_range(0, 255)), 1'b0);
      end
      drive_fcs(flip);
    end else begin
      len = (pick < 90) ? $urandom_range(1, MIN_FRAME - 1) : $urandom_range(MIN_FRAME, 40);
      for (int i = 0; i < len; i++) begin
        drive_beat(8'($urandom_range(0, 255)), i == len - 1);
      end
    end
  endtask

  initial begin : stimulus
    int frame_no;
    bit long_done;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    in_ch.is_last = 1'b0;
    row_has_exp   = 1'b0;
    row_exp       = '0;
    tx_crc        = CRC_INIT;
    burst_left    = 0;
    beats_sent    = 0;
    frame_bytes   = 0;
    longest_frame = 0;
    error_count   = 0;
    items_checked = 0;
    frames_seen   = 0;
    crc_good      = 0;
    short_frames  = 0;
    idle_cycles   = 0;
    frame_no      = 0;
    long_done     = 1'b0;
    clear_parser();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_rows[r]) begin
      row_has_exp = dir_rows[r].has_exp;
      row_exp     = dir_rows[r].exp;
      if (dir_rows[r].fcs) drive_fcs(32'd0);
      else drive_beat(dir_rows[r].data, dir_rows[r].last);
    end
    row_has_exp = 1'b0;

    // random frames; one long frame early on to hit the position cap
    while (beats_sent < ITEM_TARGET) begin
      if (!long_done && beats_sent >= 300) begin
        drive_random_frame(1'b1);
        long_done = 1'b1;
      end else begin
        drive_random_frame(1'b0);
      end
      frame_no++;
      if (frame_no % 20 == 10) begin
        // hold off between frames until every pending beat is out
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (pending_items.size() != 0);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_items.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_items.size() != 0) begin
      flag_error($sformatf("%0d expected beats never arrived", pending_items.size()));
    end

    $display("Ran %0d input beats in %0d frames; checked %0d result beats, %0d errors.",
             beats_sent, frames_seen, items_checked, error_count);
    $display("Frames with CRC match: %0d, too short: %0d, longest frame: %0d bytes.",
             crc_good, short_frames, longest_frame);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> frame_parse_crc_check_unit.f
+incdir+sv
sv/fpc_pkg.sv
sv/fpc_if.sv
sv/fpc_front.sv
sv/fpc_queue.sv
sv/fpc_back.sv
sv/frame_parse_crc_check_unit.sv
sv/fpc_checker.sv
verif/frame_parse_crc_check_unit_tb.sv
